// ===== hw/rtl/eeprom_page_transfer_splitter_defines.svh =====
// assertion macros for the page transfer splitter
`ifndef EEPROM_PAGE_TRANSFER_SPLITTER_DEFINES_SVH
`define EEPROM_PAGE_TRANSFER_SPLITTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EPTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define EPTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/epts_pkg.sv =====
package epts_pkg;

	localparam int PAGE_BYTES  = 8;
	localparam int MAX_REQUEST = 256;

	// page size is a power of two, so the page offset is a mask
	localparam int PAGE_W  = $clog2(PAGE_BYTES);
	localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);

	localparam int CAP_W   = 18;
	localparam int ADDR_W  = 17;
	localparam int COUNT_W = 9;
	localparam int PINS_W  = 3;
	localparam int CFG_W   = 18;

	localparam logic [7:0]        DEV_BASE        = 8'hA0;
	localparam logic [CAP_W-1:0]  NARROW_LIMIT    = 18'd2048;
	localparam logic [CAP_W-1:0]  WIDE_BLOCK_LIMIT = 18'd65536;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_PINS     = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [ADDR_W-1:0]  start_address;
		logic [COUNT_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  device_address;
		logic [15:0] word_address;
		logic        wide_address;
		logic [3:0]  chunk_length;
		logic        is_write;
		logic        wait_after;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPLIT
	} state_t;

	typedef struct packed {
		logic load;
		logic emit_err;
		logic emit_chunk;
	} ctl_cmd_t;

	typedef struct packed {
		logic bad;
		logic fin;
		logic slot_free;
	} ctl_stat_t;

endpackage

// ===== hw/rtl/epts_datapath.sv =====
module epts_datapath
	import epts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 res_stall,
	input  ctl_cmd_t             ctl_cmd,
	output ctl_stat_t            ctl_stat,
	output logic                 res_valid,
	output res_t                 res
);

	logic [CAP_W-1:0]   cap_q;
	logic [PINS_W-1:0]  pins_q;
	logic               wr_q;
	logic [CAP_W-1:0]   addr_q;
	logic [COUNT_W-1:0] rem_q;
	res_t               res_q;
	logic               res_valid_q;

	logic [CAP_W:0]     end_addr;
	logic [CHUNK_W-1:0] room;
	logic [CHUNK_W-1:0] n;
	logic               fin;
	logic [7:0]         base;
	logic [7:0]         dev;
	logic               wide;
	res_t               chunk_res;
	res_t               err_res;
	logic               slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(256);
			pins_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CAPACITY: cap_q  <= cfg_data;
				CFG_PINS:     pins_q <= cfg_data[PINS_W-1:0];
				default:      ;
			endcase
		end
	end

	// range check and chunk sizing
	assign end_addr = {1'b0, addr_q} + (CAP_W + 1)'(rem_q);
	assign room     = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(addr_q[PAGE_W-1:0]);
	assign fin      = rem_q <= COUNT_W'(room);
	assign n        = fin ? rem_q[CHUNK_W-1:0] : room;

	assign ctl_stat.bad = (rem_q > COUNT_W'(MAX_REQUEST)) || (end_addr > {1'b0, cap_q});
	assign ctl_stat.fin = fin;
	assign slot_free    = !res_valid_q || !res_stall;
	assign ctl_stat.slot_free = slot_free;

	assign base = DEV_BASE | {4'b0, pins_q, 1'b0};

	always_comb begin
		if (cap_q > WIDE_BLOCK_LIMIT) begin
			dev  = base + {5'b0, addr_q[17:16], 1'b0};
			wide = 1'b1;
		end else if (cap_q > NARROW_LIMIT) begin
			dev  = base;
			wide = 1'b1;
		end else begin
			dev  = base + {addr_q[14:8], 1'b0};
			wide = 1'b0;
		end
	end

	always_comb begin
		chunk_res                = '0;
		chunk_res.device_address = dev;
		chunk_res.word_address   = wide ? addr_q[15:0] : {8'b0, addr_q[7:0]};
		chunk_res.wide_address   = wide;
		chunk_res.chunk_length   = 4'(n);
		chunk_res.is_write       = wr_q;
		chunk_res.wait_after     = wr_q;
		chunk_res.last           = fin;
		err_res                  = '0;
		err_res.status           = 1'b1;
		err_res.last             = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl_cmd.load) begin
			wr_q   <= req.cmd;
			addr_q <= {1'b0, req.start_address};
			rem_q  <= req.byte_count;
		end else if (ctl_cmd.emit_chunk) begin
			addr_q <= addr_q + CAP_W'(n);
			rem_q  <= rem_q - COUNT_W'(n);
		end
		if (ctl_cmd.emit_err) begin
			res_q <= err_res;
		end else if (ctl_cmd.emit_chunk) begin
			res_q <= chunk_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl_cmd.emit_err || ctl_cmd.emit_chunk) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/epts_ctrl.sv =====
module epts_ctrl
	import epts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  ctl_stat_t ctl_stat,
	output logic      req_stall,
	output ctl_cmd_t  ctl_cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (ctl_stat.slot_free) begin
					if (ctl_stat.bad || ctl_stat.fin) state_d = ST_IDLE;
					else state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (ctl_stat.slot_free && ctl_stat.fin) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall          = 1'b1;
		ctl_cmd.load       = 1'b0;
		ctl_cmd.emit_err   = 1'b0;
		ctl_cmd.emit_chunk = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				ctl_cmd.load = req_valid;
			end
			ST_CHECK: begin
				ctl_cmd.emit_err   = ctl_stat.slot_free && ctl_stat.bad;
				ctl_cmd.emit_chunk = ctl_stat.slot_free && !ctl_stat.bad;
			end
			ST_SPLIT: begin
				ctl_cmd.emit_chunk = ctl_stat.slot_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/eeprom_page_transfer_splitter.sv =====
// first result: request loaded in ST_IDLE, result registered from ST_CHECK once the slot is free
// throughput: one chunk per cycle while the result side does not stall; the next request
// is taken only after the last chunk, and a 256-byte request gives at most 33 page chunks
// reset: arst_n async active low; capacity 256 bytes, address pins 0, no result
// pending, request side open as soon as reset is released
`include "eeprom_page_transfer_splitter_defines.svh"

module eeprom_page_transfer_splitter
	import epts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	// result channel
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	// configuration writes
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	ctl_cmd_t  ctl_cmd;
	ctl_stat_t ctl_stat;

	// sequencer: accept, range check, then one chunk per free result slot
	epts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.ctl_stat  (ctl_stat),
		.req_stall (req_stall),
		.ctl_cmd   (ctl_cmd)
	);

	// address/count registers, chunk math, config registers and result register
	epts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.ctl_cmd   (ctl_cmd),
		.ctl_stat  (ctl_stat),
		.res_valid (res_valid),
		.res       (res)
	);

	// a rejected request is a single empty result
	`EPTS_ASSERT_NOW(a_err_shape, res_valid && res.status, res.last && (res.chunk_length == 4'd0) && !res.is_write, "error result malformed")

	// no chunk is longer than a page
	`EPTS_ASSERT_NOW(a_chunk_max, res_valid, res.chunk_length <= 4'(PAGE_BYTES), "chunk longer than a page")

	// one request at a time
	`EPTS_ASSERT_NEXT(a_one_req, req_valid && !req_stall, req_stall, "request taken while busy")

endmodule

// ===== tb/tb_eeprom_page_transfer_splitter.sv =====
`timescale 1ns / 100ps

module tb_eeprom_page_transfer_splitter;
	import epts_pkg::*;

	// request and command codes as the block sees them
	localparam logic REQ_READ         = 1'b0;
	localparam logic REQ_WRITE        = 1'b1;
	localparam logic CMD_OK           = 1'b0;
	localparam logic CMD_OUT_OF_RANGE = 1'b1;

	// highest byte address a request can name
	localparam int unsigned ADDR_MAX = (1 << ADDR_W) - 1;

	// cycles to let the split loop finish before touching the registers
	localparam int SETTLE_CYCLES  = 40;
	// cycles with no request or command moving before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;
	logic             cfg_write = 1'b0;
	logic             cfg_index = CFG_CAPACITY;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor copy of the two registers, reset values first
	logic [CAP_W-1:0]  mem_capacity = CAP_W'(256);
	logic [PINS_W-1:0] chip_pins = '0;

	req_t pending_requests[$];
	res_t expected_cmds[$];
	res_t want;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	// when set, neither side idles or stalls
	logic steady = 1'b0;

	eeprom_page_transfer_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// work out the bus commands one request turns into, in order
	function automatic void predict_commands(req_t r);
		int unsigned at;
		int unsigned left;
		int unsigned n;
		logic [7:0]  dev_base;
		res_t        c;
		at = 32'(r.start_address);
		left = 32'(r.byte_count);
		dev_base = DEV_BASE | {4'b0000, chip_pins, 1'b0};
		// oversized or running past the end of the memory: one rejection only
		if (left > MAX_REQUEST || at + left > mem_capacity) begin
			c = '0;
			c.status = CMD_OUT_OF_RANGE;
			c.last = 1'b1;
			expected_cmds.push_back(c);
			return;
		end
		// first chunk runs to the end of its page, a zero count still gives one
		n = PAGE_BYTES - (at % PAGE_BYTES);
		if (left <= n)
			n = left;
		forever begin
			c = '0;
			c.status = CMD_OK;
			if (mem_capacity > WIDE_BLOCK_LIMIT) begin
				// two address bytes, bit 16 up folded into the device byte
				c.device_address = dev_base + 8'((at >> 16) << 1);
				c.word_address = 16'(at);
				c.wide_address = 1'b1;
			end else if (mem_capacity > NARROW_LIMIT) begin
				c.device_address = dev_base;
				c.word_address = 16'(at);
				c.wide_address = 1'b1;
			end else begin
				// one address byte, bits 10..8 ride in the device byte
				c.device_address = dev_base + 8'((at >> 8) << 1);
				c.word_address = 16'(at & 32'hFF);
				c.wide_address = 1'b0;
			end
			c.chunk_length = 4'(n);
			c.is_write = r.cmd;
			c.wait_after = r.cmd;
			c.last = (n == left);
			expected_cmds.push_back(c);
			if (n == left)
				break;
			at += n;
			left -= n;
			n = (left < PAGE_BYTES) ? left : PAGE_BYTES;
		end
	endfunction

	// random request shaped by the current capacity
	function automatic req_t random_request();
		req_t        r;
		int unsigned cap;
		int unsigned roll;
		int unsigned count;
		int unsigned start;
		int unsigned span;
		cap = 32'(mem_capacity);
		roll = $urandom_range(0, 99);
		r.cmd = 1'($urandom_range(0, 1));
		// plain noise over the whole field ranges, oversized counts included
		if (roll < 8) begin
			r.start_address = ADDR_W'($urandom);
			r.byte_count = COUNT_W'($urandom);
			return r;
		end
		count = (roll < 60) ? $urandom_range(0, 24) : $urandom_range(0, MAX_REQUEST);
		if (roll < 20) begin
			// aim just past the end of the memory
			if (count == 0)
				count = 1;
			if (cap >= count)
				start = cap - count + $urandom_range(1, count);
			else
				start = $urandom_range(0, ADDR_MAX);
			if (start > ADDR_MAX)
				start = ADDR_MAX;
		end else begin
			// well-formed request that fits
			if (count > cap)
				count = cap;
			span = cap - count;
			if (span > ADDR_MAX)
				span = ADDR_MAX;
			start = $urandom_range(0, span);
			// lean on page starts and page ends
			if ($urandom_range(0, 3) == 0) begin
				start = (start & ~32'd7) | ($urandom_range(0, 1) ? 32'd7 : 32'd0);
				if (start > span)
					start = span;
			end
		end
		r.start_address = ADDR_W'(start);
		r.byte_count = COUNT_W'(count);
		return r;
	endfunction

	task automatic add_request(logic op, int unsigned start, int unsigned count);
		req_t r;
		r.cmd = op;
		r.start_address = ADDR_W'(start);
		r.byte_count = COUNT_W'(count);
		pending_requests.push_back(r);
	endtask

	// block idle: all requests taken, all commands back, split loop quiet
	task automatic settle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_cmds.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, only while the block is idle
	task automatic program_memory(int unsigned cap, int unsigned pins);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_data <= CFG_W'(cap);
		@(posedge clk);
		cfg_index <= CFG_PINS;
		cfg_data <= CFG_W'(pins);
		@(posedge clk);
		cfg_write <= 1'b0;
		mem_capacity = CAP_W'(cap);
		chip_pins = PINS_W'(pins);
	endtask

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// request driver: holds a stalled request, may idle between requests
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				predict_commands(req);
			if (!req_valid || !req_stall) begin
				if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
					req <= pending_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// command monitor: random backpressure, compare against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_cmds.size() == 0) begin
					$display("%0t: unexpected command, actual %h", $time, res);
					mismatches++;
				end else begin
					want = expected_cmds.pop_front();
					check_field("status", want.status, res.status);
					check_field("device_address", want.device_address, res.device_address);
					check_field("word_address", want.word_address, res.word_address);
					check_field("wide_address", want.wide_address, res.wide_address);
					check_field("chunk_length", want.chunk_length, res.chunk_length);
					check_field("is_write", want.is_write, res.is_write);
					check_field("wait_after", want.wait_after, res.wait_after);
					check_field("last", want.last, res.last);
				end
			end
			res_stall <= !steady && ($urandom_range(0, 99) < 16);
		end
	end

	// hang detector: any moving request or command resets the count
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned phase_cap[9];
		int unsigned phase_pins[9];
		phase_cap = '{256, 128, 2048, 2049, 65536, 65537, 131072, 1000, 100000};
		phase_pins = '{0, 7, 3, 5, 2, 6, 1, 4, 7};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 256 bytes, pins 0, narrow addressing
		@(negedge clk);
		add_request(REQ_READ, 0, 0);         // zero count, single empty command
		add_request(REQ_WRITE, 0, PAGE_BYTES);
		add_request(REQ_WRITE, 3, PAGE_BYTES); // crosses a page
		add_request(REQ_READ, 7, 1);
		add_request(REQ_WRITE, 0, MAX_REQUEST); // whole memory
		add_request(REQ_READ, 1, MAX_REQUEST);  // one byte past the end
		add_request(REQ_WRITE, 5, MAX_REQUEST + 1); // oversized
		add_request(REQ_READ, 0, 511);
		add_request(REQ_WRITE, 255, 1);
		add_request(REQ_READ, 256, 0);       // empty request right at the end
		add_request(REQ_WRITE, 256, 1);
		add_request(REQ_READ, ADDR_MAX, MAX_REQUEST);
		settle();

		// largest memory, block bits above 16 in the device byte
		program_memory(131072, 7);
		@(negedge clk);
		add_request(REQ_WRITE, 3, MAX_REQUEST); // most chunks a request can give
		add_request(REQ_READ, 65532, 20);    // crosses into the upper block
		add_request(REQ_WRITE, ADDR_MAX, 1);
		add_request(REQ_READ, 131068, 4);
		add_request(REQ_WRITE, ADDR_MAX, 0);
		add_request(REQ_READ, 131070, 3);
		settle();

		// narrow mode edge, highest block bits
		program_memory(2048, 7);
		@(negedge clk);
		add_request(REQ_WRITE, 2047, 1);
		add_request(REQ_READ, 2040, PAGE_BYTES);
		add_request(REQ_WRITE, 2048, 0);
		add_request(REQ_READ, 1790, 20);
		settle();

		// zero capacity takes only empty requests at address 0
		program_memory(0, 0);
		@(negedge clk);
		add_request(REQ_READ, 0, 0);
		add_request(REQ_WRITE, 0, 1);
		settle();

		// capacity beyond any address, nothing is out of range
		program_memory((1 << CAP_W) - 1, 5);
		@(negedge clk);
		add_request(REQ_WRITE, ADDR_MAX, MAX_REQUEST);
		settle();

		// random phases across the addressing modes, a long calm stretch in the middle
		for (int p = 0; p < 9; p++) begin
			program_memory(phase_cap[p], phase_pins[p]);
			@(negedge clk);
			steady = (p == 3 || p == 4);
			repeat (56) pending_requests.push_back(random_request());
			settle();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/epts_pkg.sv
hw/rtl/epts_datapath.sv
hw/rtl/epts_ctrl.sv
hw/rtl/eeprom_page_transfer_splitter.sv
tb/tb_eeprom_page_transfer_splitter.sv
